// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ----- rtl/stas_pkg.sv -----
// Package for the sparse triplet add and sort block: types, constants, helpers.
`timescale 1ns / 1ps

package stas_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int IDX_W        = 16;
    localparam int VAL_W        = 32;
    localparam int KEY_W        = 2 * IDX_W;
    localparam int ENTRY_W      = KEY_W + VAL_W;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } stas_state_t;

    // Signed add that clamps to the value range.
    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/stas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word into the output register
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sparse_triplet_add_sort_top.sv -----
// Top level of the sparse triplet add and sort block.
`timescale 1ns / 1ps
// Usage:
//   Slave channel: each word is a load (s_tuser = 0) of one (row, col, value)
//   triplet or a finish command (s_tuser = 1). Loads are taken while idle and
//   give no result; loads into a full store are dropped and set a sticky
//   overflow flag.
//   On finish the stored entries are scanned once per distinct coordinate
//   pair through the single read port of the entry RAM: each pass finds the
//   next larger (row, col) key and sums its values in load order with
//   saturation. A finish lasts until its last word is taken, receiver stalls
//   included; s_tready is low meanwhile.
//   Master channel: one word per merged entry in ascending (row, col) order,
//   m_tlast on the final word. An empty store gives one word with the empty
//   flag set and zero data. The overflow flag rides on every word of a run.
//   A word is held in the output register until m_tready takes it.
//   Reset (aresetn low, synchronous) empties the store and clears the flag;
//   stored RAM contents are not cleared, only the fill count.
module sparse_triplet_add_sort_top
    import stas_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_row[15:0], entry_col[31:16], entry_value[63:32]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_row[15:0], out_col[31:16], out_value[63:32]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // is_empty[0], overflowed[1]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    stas_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic          empty_reg, empty_next;
    logic          found_reg, found_next;
    logic          have_prev_reg, have_prev_next;
    logic [CW-1:0] match_reg, match_next;
    logic [CW-1:0] done_reg, done_next;
    logic [KEY_W-1:0] prev_key_reg, prev_key_next;
    logic [KEY_W-1:0] cand_key_reg, cand_key_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic signed [VAL_W-1:0] rd_val;
    logic [CW-1:0]      seen_sum;
    logic               is_last;
    logic               in_word;
    logic               out_word;
    logic               qualify;

    stas_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Unpack the entry read back from the store
    assign rd_key = {ram_rdata[IDX_W-1:0], ram_rdata[KEY_W-1:IDX_W]};
    assign rd_val = ram_rdata[ENTRY_W-1:KEY_W];

    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;
    assign seen_sum = done_reg + match_reg;
    assign is_last  = empty_reg || (seen_sum == count_reg);
    assign qualify  = !have_prev_reg || (rd_key > prev_key_reg);

    // Drive the channels from registers
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {acc_reg, cand_key_reg[IDX_W-1:0], cand_key_reg[KEY_W-1:IDX_W]};
    assign m_tlast  = is_last;
    assign m_tuser  = {ovf_reg, empty_reg};

    // Sequencer: load, scan passes, emit
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        empty_next     = empty_reg;
        found_next     = found_reg;
        have_prev_next = have_prev_reg;
        match_next     = match_reg;
        done_next      = done_reg;
        prev_key_next  = prev_key_reg;
        cand_key_next  = cand_key_reg;
        acc_next       = acc_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_word) begin
                    if (s_tuser[0] == CMD_LOAD) begin
                        // Store the triplet or drop it when full
                        if (count_reg < CW'(CAPACITY)) begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else if (count_reg == '0) begin
                        empty_next    = 1'b1;
                        cand_key_next = '0;
                        acc_next      = '0;
                        state_next    = ST_EMIT;
                    end else begin
                        rd_idx_next    = '0;
                        pend_next      = 1'b0;
                        found_next     = 1'b0;
                        have_prev_next = 1'b0;
                        done_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue the next read address
                pend_next = (rd_idx_reg < count_reg);
                if (rd_idx_reg < count_reg) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                // Track the smallest key above the last one emitted
                if (pend_reg && qualify) begin
                    if (!found_reg || (rd_key < cand_key_reg)) begin
                        found_next    = 1'b1;
                        cand_key_next = rd_key;
                        acc_next      = rd_val;
                        match_next    = CW'(1);
                    end else if (rd_key == cand_key_reg) begin
                        acc_next   = sat_add(acc_reg, rd_val);
                        match_next = match_reg + CW'(1);
                    end
                end
                if ((rd_idx_reg == count_reg) && !pend_reg) begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_word) begin
                    if (is_last) begin
                        // End of run: empty the store
                        count_next = '0;
                        ovf_next   = 1'b0;
                        empty_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        prev_key_next  = cand_key_reg;
                        have_prev_next = 1'b1;
                        done_next      = seen_sum;
                        rd_idx_next    = '0;
                        pend_next      = 1'b0;
                        found_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            empty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            empty_reg <= empty_next;
        end
    end

    // Scan and payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        found_reg     <= found_next;
        have_prev_reg <= have_prev_next;
        match_reg     <= match_next;
        done_reg      <= done_next;
        prev_key_reg  <= prev_key_next;
        cand_key_reg  <= cand_key_next;
        acc_reg       <= acc_next;
    end

endmodule

// ----- rtl/stas_checker.sv -----
// Port-level checker for the sparse triplet add and sort block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stas_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // No new word is taken while a result word is pending
    `ASSERT_STD(a_no_load_while_emit, !(s_tready && m_tvalid), "ready while result pending")

    // The empty answer is the only word of its run
    `ASSERT_STD(a_empty_is_last, (m_tvalid && m_tuser[0]) |-> m_tlast, "empty word not last")

    // The empty answer carries zero data
    `ASSERT_STD(a_empty_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0), "empty word data")

    // A stalled result word holds
    `ASSERT_STD(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "word dropped")

endmodule

bind sparse_triplet_add_sort_top stas_port_checker u_stas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
